>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

>>> hdl/tga_pkg.sv
// ----------------------------------------------------------------------------
// tga_pkg
// Types, codes and constants of the truecolor TGA decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tga_pkg;

  // Decode phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_PLAIN  = 3'd1;
  localparam logic [2:0] PH_PACKET = 3'd2;
  localparam logic [2:0] PH_RAW    = 3'd3;
  localparam logic [2:0] PH_RUN    = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;
  localparam logic [2:0] PH_STOP   = 3'd6;

  // Status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_SIG   = 2'd1;
  localparam logic [1:0] STATUS_BAD_ATTR  = 2'd2;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

  // Header byte positions
  localparam logic [4:0] HDR_SIG_LEN  = 5'd12;
  localparam logic [4:0] HDR_TYPE_IDX = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_BPP_IDX  = 5'd16;
  localparam logic [4:0] HDR_LEN      = 5'd18;

  localparam logic [7:0] TYPE_RAW  = 8'd2;
  localparam logic [7:0] TYPE_RLE  = 8'd10;
  localparam logic [7:0] BPP_24    = 8'd24;
  localparam logic [7:0] BPP_32    = 8'd32;
  localparam logic [7:0] RAW_LIMIT = 8'd128;
  localparam logic [7:0] RUN_BIAS  = 8'd127;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        pixel_present;
    logic        image_done;
    logic [1:0]  decode_status;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  pixel_bytes;
    logic        header_accepted;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [4:0]  header_index;
    logic        is_compressed;
    logic        signature_ok;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  bytes_per_pixel;
    logic [31:0] pixels_left;
    logic [7:0]  raw_left;
    logic [7:0]  run_length;
    logic [1:0]  byte_in_pixel;
    logic [31:0] pixel_assembly;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:           PH_HEADER,
    header_index:    5'd0,
    is_compressed:   1'b0,
    signature_ok:    1'b1,
    width:           16'd0,
    height:          16'd0,
    bytes_per_pixel: 3'd0,
    pixels_left:     32'd0,
    raw_left:        8'd0,
    run_length:      8'd0,
    byte_in_pixel:   2'd0,
    pixel_assembly:  32'd0
  };

endpackage

`default_nettype wire

>>> hdl/tga_stream_if.sv
// ----------------------------------------------------------------------------
// tga_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface tga_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/tga_rle_image_decoder.sv
// ----------------------------------------------------------------------------
// tga_rle_image_decoder
// Truecolor TGA (type 2 / type 10) byte-stream decoder, one byte per cycle.
// An accepted byte is held in the input register, its result in the result
// register. Throughput: one byte per cycle; the input register and the result
// register each advance whenever the result register is empty or being taken.
// Reset (rst, synchronous) empties both registers and returns the decoder to
// header byte 0; a byte with first_byte set does the same for its own file.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tga_rle_image_decoder (
  input  wire             clk,
  input  wire             rst,
  tga_stream_if.sink      stream,
  tga_stream_if.source    result
);

  logic               s1_valid;
  tga_pkg::in_item_t  s1_item;
  tga_pkg::state_t    state;
  tga_pkg::state_t    state_next;
  logic               step_emit;
  tga_pkg::out_item_t step_res;
  logic               out_valid;
  tga_pkg::out_item_t out_item;
  logic               out_free;
  logic               advance;

  assign out_free = !out_valid || result.ready;
  assign advance = s1_valid && out_free;
  assign stream.ready = !s1_valid || advance;
  assign result.valid = out_valid;
  assign result.payload = out_item;

  tga_step u_step (
    .state      (state),
    .item       (s1_item),
    .state_next (state_next),
    .emit       (step_emit),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
      state <= tga_pkg::STATE_RESET;
    end else begin
      if (stream.ready) begin
        s1_valid <= stream.valid;
      end
      if (advance) begin
        state <= state_next;
      end
      if (out_free) begin
        out_valid <= advance && step_emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      s1_item <= stream.payload;
    end
    if (advance && step_emit) begin
      out_item <= step_res;
    end
  end

  `ASSERT_ALWAYS(a_hidx_range, clk, rst, state.header_index <= tga_pkg::HDR_LEN)
  `ASSERT_IMPLY(a_done_empty, clk, rst, state.phase == tga_pkg::PH_DONE,
                state.pixels_left == 32'd0)
  `ASSERT_IMPLY(a_bpp_in_data, clk, rst,
                state.phase == tga_pkg::PH_PLAIN || state.phase == tga_pkg::PH_RAW ||
                state.phase == tga_pkg::PH_RUN,
                state.bytes_per_pixel == 3'd3 || state.bytes_per_pixel == 3'd4)
  `ASSERT_IMPLY(a_pixel_rep, clk, rst, out_valid && out_item.pixel_present,
                out_item.repeat_count != 8'd0)
  `ASSERT_IMPLY(a_done_has_pixel, clk, rst, out_valid && out_item.image_done,
                out_item.pixel_present)

endmodule

`default_nettype wire

>>> hdl/tga_step.sv
// ----------------------------------------------------------------------------
// tga_step
// Next-state and result logic for one file byte of the TGA decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_step (
  input  tga_pkg::state_t    state,
  input  tga_pkg::in_item_t  item,
  output tga_pkg::state_t    state_next,
  output logic               emit,
  output tga_pkg::out_item_t res
);

  tga_pkg::state_t cur;
  logic [31:0] pix_word;
  logic        pix_done;
  logic [31:0] area;
  logic [7:0]  rep;
  logic [31:0] left_after;
  logic [4:0]  hidx_inc;

  always_comb begin
    cur = item.first_byte ? tga_pkg::STATE_RESET : state;
    pix_word = cur.pixel_assembly | (32'(item.data_byte) << {cur.byte_in_pixel, 3'b000});
    pix_done = ({1'b0, cur.byte_in_pixel} + 3'd1) >= cur.bytes_per_pixel;
    area = 32'(cur.width) * 32'(cur.height);
    // run repeat clipped to what remains of the image
    if (cur.phase == tga_pkg::PH_RUN) begin
      rep = (32'(cur.run_length) < cur.pixels_left) ? cur.run_length
                                                     : cur.pixels_left[7:0];
    end else begin
      rep = 8'd1;
    end
    left_after = cur.pixels_left - 32'(rep);
    hidx_inc = cur.header_index + 5'd1;
  end

  always_comb begin
    state_next = cur;
    emit = 1'b0;
    res = '0;
    res.decode_status = tga_pkg::STATUS_OK;

    unique case (cur.phase)
      tga_pkg::PH_HEADER: begin
        if (cur.header_index < tga_pkg::HDR_SIG_LEN) begin
          if (cur.header_index == tga_pkg::HDR_TYPE_IDX) begin
            if (item.data_byte == tga_pkg::TYPE_RAW) begin
              state_next.is_compressed = 1'b0;
            end else if (item.data_byte == tga_pkg::TYPE_RLE) begin
              state_next.is_compressed = 1'b1;
            end else begin
              state_next.signature_ok = 1'b0;
            end
          end else if (item.data_byte != 8'd0) begin
            state_next.signature_ok = 1'b0;
          end
        end else if (cur.header_index == tga_pkg::HDR_WIDTH_LO) begin
          state_next.width[7:0] = item.data_byte;
        end else if (cur.header_index == tga_pkg::HDR_WIDTH_HI) begin
          state_next.width[15:8] = item.data_byte;
        end else if (cur.header_index == tga_pkg::HDR_HEIGHT_LO) begin
          state_next.height[7:0] = item.data_byte;
        end else if (cur.header_index == tga_pkg::HDR_HEIGHT_HI) begin
          state_next.height[15:8] = item.data_byte;
        end else if (cur.header_index == tga_pkg::HDR_BPP_IDX) begin
          if (item.data_byte == tga_pkg::BPP_24) begin
            state_next.bytes_per_pixel = 3'd3;
          end else if (item.data_byte == tga_pkg::BPP_32) begin
            state_next.bytes_per_pixel = 3'd4;
          end else begin
            state_next.bytes_per_pixel = 3'd0;
          end
        end
        state_next.header_index = hidx_inc;
        if (hidx_inc == tga_pkg::HDR_LEN) begin
          // last header byte never touches width/height/bpp, so cur is final
          emit = 1'b1;
          if (cur.width == 16'd0 || cur.height == 16'd0 || cur.bytes_per_pixel == 3'd0) begin
            res.decode_status = tga_pkg::STATUS_BAD_ATTR;
            state_next.bytes_per_pixel = 3'd0;
            state_next.phase = tga_pkg::PH_STOP;
          end else if (!cur.signature_ok) begin
            res.decode_status = tga_pkg::STATUS_BAD_SIG;
            state_next.bytes_per_pixel = 3'd0;
            state_next.phase = tga_pkg::PH_STOP;
          end else begin
            res.header_accepted = 1'b1;
            state_next.pixels_left = area;
            state_next.phase = cur.is_compressed ? tga_pkg::PH_PACKET : tga_pkg::PH_PLAIN;
          end
        end
      end
      tga_pkg::PH_PACKET: begin
        if (item.data_byte < tga_pkg::RAW_LIMIT) begin
          state_next.raw_left = item.data_byte + 8'd1;
          state_next.phase = tga_pkg::PH_RAW;
        end else begin
          state_next.run_length = item.data_byte - tga_pkg::RUN_BIAS;
          state_next.phase = tga_pkg::PH_RUN;
        end
      end
      tga_pkg::PH_PLAIN, tga_pkg::PH_RAW, tga_pkg::PH_RUN: begin
        state_next.pixel_assembly = pix_word;
        if (pix_done) begin
          state_next.byte_in_pixel = 2'd0;
          state_next.pixel_assembly = 32'd0;
          state_next.pixels_left = left_after;
          emit = 1'b1;
          res.pixel_present = 1'b1;
          res.pixel_value = pix_word;
          res.repeat_count = rep;
          if (left_after == 32'd0) begin
            res.image_done = 1'b1;
            state_next.phase = tga_pkg::PH_DONE;
          end else if (cur.phase == tga_pkg::PH_RAW) begin
            state_next.raw_left = cur.raw_left - 8'd1;
            if (cur.raw_left == 8'd1) begin
              state_next.phase = tga_pkg::PH_PACKET;
            end
          end else if (cur.phase == tga_pkg::PH_RUN) begin
            state_next.phase = tga_pkg::PH_PACKET;
          end
        end else begin
          state_next.byte_in_pixel = cur.byte_in_pixel + 2'd1;
        end
      end
      default: begin
      end
    endcase

    // end of supplied data before the image completed
    if (item.final_byte && state_next.phase <= tga_pkg::PH_RUN) begin
      emit = 1'b1;
      res.decode_status = tga_pkg::STATUS_TRUNCATED;
      state_next.phase = tga_pkg::PH_STOP;
    end

    res.image_width = state_next.width;
    res.image_height = state_next.height;
    res.pixel_bytes = (state_next.header_index == tga_pkg::HDR_LEN) ?
                      state_next.bytes_per_pixel : 3'd0;
  end

endmodule

`default_nettype wire

>>> tb/tga_rle_image_decoder_test.sv
// ----------------------------------------------------------------------------
// tga_rle_image_decoder_test
// Self-checking bench for the TGA byte-stream decoder. A short table of
// hand-picked bytes is followed by random files: well-formed type 2 and
// type 10 images, corrupt signatures and attributes, cut-off files and noise.
// Every accepted byte runs through a behavioral decoder in the bench; each
// result transaction is checked field by field against it or a typed row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tga_rle_image_decoder_test;

  localparam int TARGET_ITEMS = 550;
  localparam int QUIET_AFTER  = 480;
  localparam int LONG_HOLD    = 250;

  typedef struct {
    tga_pkg::in_item_t  item;
    bit                 typed;
    tga_pkg::out_item_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  tga_stream_if #(.payload_t(tga_pkg::in_item_t))  byte_ch ();
  tga_stream_if #(.payload_t(tga_pkg::out_item_t)) pix_ch ();

  tga_rle_image_decoder uut (
    .clk    (clk),
    .rst    (rst),
    .stream (byte_ch),
    .result (pix_ch)
  );

  // Behavioral decoder state
  logic [2:0]  dec_phase;
  logic [4:0]  hdr_pos;
  logic        rle_mode;
  logic        sig_good;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic [2:0]  px_bytes;
  logic [31:0] px_remaining;
  logic [7:0]  raw_count;
  logic [7:0]  run_count;
  logic [1:0]  byte_pos;
  logic [31:0] px_accum;

  tga_pkg::out_item_t pending_results[$];
  dir_row_t           dir_table[$];
  tga_pkg::in_item_t  file_bytes[$];

  bit quiet;
  bit stall_req;
  int errors;
  int busy_items;
  int pixel_results;
  int status_results;
  int files_sent;
  int odd_files;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d results still pending", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void clear_decoder();
    dec_phase    = tga_pkg::PH_HEADER;
    hdr_pos      = '0;
    rle_mode     = 1'b0;
    sig_good     = 1'b1;
    img_w        = '0;
    img_h        = '0;
    px_bytes     = '0;
    px_remaining = '0;
    raw_count    = '0;
    run_count    = '0;
    byte_pos     = '0;
    px_accum     = '0;
  endfunction

  // Advance the decoder by one byte; returns 1 when the byte yields a result.
  function automatic bit decode_byte(input tga_pkg::in_item_t it,
                                     output tga_pkg::out_item_t r,
                                     output bit skipped);
    logic [7:0]  b;
    logic [31:0] rep;
    bit          emit;
    b    = it.data_byte;
    rep  = '0;
    emit = 1'b0;
    r    = '0;
    if (it.first_byte) clear_decoder();
    skipped = (dec_phase >= tga_pkg::PH_DONE);
    case (dec_phase)
      tga_pkg::PH_HEADER: begin
        if (hdr_pos < tga_pkg::HDR_SIG_LEN) begin
          if (hdr_pos == tga_pkg::HDR_TYPE_IDX) begin
            if (b == tga_pkg::TYPE_RAW) rle_mode = 1'b0;
            else if (b == tga_pkg::TYPE_RLE) rle_mode = 1'b1;
            else sig_good = 1'b0;
          end else if (b != 8'd0) begin
            sig_good = 1'b0;
          end
        end else if (hdr_pos == tga_pkg::HDR_WIDTH_LO) begin
          img_w[7:0] = b;
        end else if (hdr_pos == tga_pkg::HDR_WIDTH_HI) begin
          img_w[15:8] = b;
        end else if (hdr_pos == tga_pkg::HDR_HEIGHT_LO) begin
          img_h[7:0] = b;
        end else if (hdr_pos == tga_pkg::HDR_HEIGHT_HI) begin
          img_h[15:8] = b;
        end else if (hdr_pos == tga_pkg::HDR_BPP_IDX) begin
          px_bytes = (b == tga_pkg::BPP_24) ? 3'd3 : ((b == tga_pkg::BPP_32) ? 3'd4 : 3'd0);
        end
        hdr_pos = hdr_pos + 5'd1;
        if (hdr_pos == tga_pkg::HDR_LEN) begin
          emit = 1'b1;
          // attributes are checked ahead of the signature
          if (img_w == 16'd0 || img_h == 16'd0 || px_bytes == 3'd0) begin
            r.decode_status = tga_pkg::STATUS_BAD_ATTR;
            px_bytes = '0;
            dec_phase = tga_pkg::PH_STOP;
          end else if (!sig_good) begin
            r.decode_status = tga_pkg::STATUS_BAD_SIG;
            px_bytes = '0;
            dec_phase = tga_pkg::PH_STOP;
          end else begin
            r.header_accepted = 1'b1;
            px_remaining = {16'd0, img_w} * {16'd0, img_h};
            dec_phase = rle_mode ? tga_pkg::PH_PACKET : tga_pkg::PH_PLAIN;
          end
        end
      end
      tga_pkg::PH_PACKET: begin
        if (b < tga_pkg::RAW_LIMIT) begin
          raw_count = b + 8'd1;
          dec_phase = tga_pkg::PH_RAW;
        end else begin
          run_count = b - tga_pkg::RUN_BIAS;
          dec_phase = tga_pkg::PH_RUN;
        end
      end
      tga_pkg::PH_PLAIN, tga_pkg::PH_RAW, tga_pkg::PH_RUN: begin
        px_accum = px_accum | ({24'd0, b} << (8 * byte_pos));
        if (int'(byte_pos) + 1 >= int'(px_bytes)) begin
          byte_pos = '0;
          emit = 1'b1;
          r.pixel_present = 1'b1;
          r.pixel_value = px_accum;
          px_accum = '0;
          rep = 32'd1;
          // runs are clipped to what is left of the image
          if (dec_phase == tga_pkg::PH_RUN)
            rep = ({24'd0, run_count} < px_remaining) ? {24'd0, run_count} : px_remaining;
          px_remaining = px_remaining - rep;
          if (px_remaining == 32'd0) begin
            r.image_done = 1'b1;
            dec_phase = tga_pkg::PH_DONE;
          end else if (dec_phase == tga_pkg::PH_RAW) begin
            raw_count = raw_count - 8'd1;
            if (raw_count == 8'd0) dec_phase = tga_pkg::PH_PACKET;
          end else if (dec_phase == tga_pkg::PH_RUN) begin
            dec_phase = tga_pkg::PH_PACKET;
          end
        end else begin
          byte_pos = byte_pos + 2'd1;
        end
      end
      default: ;
    endcase
    if (it.final_byte && dec_phase <= tga_pkg::PH_RUN) begin
      emit = 1'b1;
      r.decode_status = tga_pkg::STATUS_TRUNCATED;
      dec_phase = tga_pkg::PH_STOP;
    end
    r.repeat_count = rep[7:0];
    r.image_width  = img_w;
    r.image_height = img_h;
    r.pixel_bytes  = (hdr_pos == tga_pkg::HDR_LEN) ? px_bytes : 3'd0;
    return emit;
  endfunction

  function automatic tga_pkg::out_item_t mk_out(logic [31:0] pix, logic [7:0] rep,
                                                logic present, logic done,
                                                logic [1:0] status, logic [15:0] w,
                                                logic [15:0] h, logic [2:0] nbytes,
                                                logic hacc);
    tga_pkg::out_item_t r;
    r.pixel_value     = pix;
    r.repeat_count    = rep;
    r.pixel_present   = present;
    r.image_done      = done;
    r.decode_status   = status;
    r.image_width     = w;
    r.image_height    = h;
    r.pixel_bytes     = nbytes;
    r.header_accepted = hacc;
    return r;
  endfunction

  task automatic add_row(logic [7:0] b, logic first, logic fin, bit typed = 1'b0,
                         tga_pkg::out_item_t want = '0);
    dir_row_t row;
    row.item  = '{data_byte: b, first_byte: first, final_byte: fin};
    row.typed = typed;
    row.want  = want;
    dir_table.push_back(row);
  endtask

  task automatic feed_byte(tga_pkg::in_item_t it, bit typed, tga_pkg::out_item_t want);
    tga_pkg::out_item_t r;
    bit                 skipped;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.payload <= it;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    if (decode_byte(it, r, skipped)) pending_results.push_back(typed ? want : r);
    if (!skipped) busy_items++;
  endtask

  task automatic push_byte(logic [7:0] b);
    file_bytes.push_back('{data_byte: b, first_byte: 1'b0, final_byte: 1'b0});
  endtask

  task automatic push_pixel(int nbytes);
    repeat (nbytes) push_byte(8'($urandom_range(0, 255)));
  endtask

  // Build one random file into file_bytes; odd is set for all but clean or huge.
  task automatic build_file(output bit odd);
    int                sel, w, h, nbytes, left, n, cut, idx, cap;
    logic [7:0]        ftype, bpp;
    logic [7:0]        hdr [18];
    tga_pkg::in_item_t it;
    file_bytes.delete();
    sel    = $urandom_range(0, 99);
    odd    = (sel >= 72);
    w      = $urandom_range(1, 3);
    h      = $urandom_range(1, 3);
    bpp    = ($urandom_range(0, 1) != 0) ? tga_pkg::BPP_32 : tga_pkg::BPP_24;
    ftype  = ($urandom_range(0, 1) != 0) ? tga_pkg::TYPE_RLE : tga_pkg::TYPE_RAW;
    cap    = 4000;
    if (sel >= 60 && sel < 68) begin
      w = $urandom_range(128, 1024);
      h = 1;
      ftype = tga_pkg::TYPE_RLE;
    end else if (sel >= 68 && sel < 72) begin
      // huge dimensions, cut off after a handful of runs
      w = $urandom_range(1, 65535);
      h = $urandom_range(2, 65535);
      ftype = tga_pkg::TYPE_RLE;
      cap = 60;
    end
    if (sel >= 96) begin
      n = $urandom_range(1, 20);
      repeat (n) begin
        it.data_byte  = 8'($urandom_range(0, 255));
        it.first_byte = ($urandom_range(0, 7) == 0);
        it.final_byte = ($urandom_range(0, 5) == 0);
        file_bytes.push_back(it);
      end
      return;
    end
    for (idx = 0; idx < int'(tga_pkg::HDR_SIG_LEN); idx++) hdr[idx] = 8'd0;
    hdr[tga_pkg::HDR_TYPE_IDX]  = ftype;
    hdr[tga_pkg::HDR_WIDTH_LO]  = w[7:0];
    hdr[tga_pkg::HDR_WIDTH_HI]  = w[15:8];
    hdr[tga_pkg::HDR_HEIGHT_LO] = h[7:0];
    hdr[tga_pkg::HDR_HEIGHT_HI] = h[15:8];
    hdr[tga_pkg::HDR_BPP_IDX]   = bpp;
    hdr[tga_pkg::HDR_LEN - 5'd1] = 8'($urandom_range(0, 255));
    if (sel >= 72 && sel < 80) begin
      idx = $urandom_range(0, 11);
      hdr[idx] = (idx == int'(tga_pkg::HDR_TYPE_IDX)) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(1, 255));
    end else if (sel >= 80 && sel < 88) begin
      case ($urandom_range(0, 2))
        0: begin
          hdr[tga_pkg::HDR_WIDTH_LO] = 8'd0;
          hdr[tga_pkg::HDR_WIDTH_HI] = 8'd0;
        end
        1: begin
          hdr[tga_pkg::HDR_HEIGHT_LO] = 8'd0;
          hdr[tga_pkg::HDR_HEIGHT_HI] = 8'd0;
        end
        default: hdr[tga_pkg::HDR_BPP_IDX] = 8'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 3) == 0) hdr[$urandom_range(0, 11)] = 8'hFF;
    end
    for (idx = 0; idx < int'(tga_pkg::HDR_LEN); idx++) push_byte(hdr[idx]);
    nbytes = (bpp == tga_pkg::BPP_32) ? 4 : 3;
    if (ftype == tga_pkg::TYPE_RAW) begin
      repeat (w * h) push_pixel(nbytes);
    end else begin
      left = w * h;
      while (left > 0 && file_bytes.size() < cap) begin
        if (sel < 60 && $urandom_range(0, 1) != 0) begin
          // raw packet, may run past the end of the image
          n = $urandom_range(1, 8);
          push_byte(8'(n - 1));
          repeat (n) push_pixel(nbytes);
        end else begin
          n = $urandom_range(1, 128);
          push_byte(8'(int'(tga_pkg::RUN_BIAS) + n));
          push_pixel(nbytes);
        end
        left = (n >= left) ? 0 : left - n;
      end
    end
    if (sel < 60 && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push_pixel(1);
    if (sel >= 88 && sel < 96) begin
      cut = $urandom_range(1, file_bytes.size() - 1);
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
    it = file_bytes.pop_front();
    it.first_byte = 1'b1;
    file_bytes.push_front(it);
    if ((sel >= 68 && sel < 72) || (sel >= 88 && sel < 96) || $urandom_range(0, 1) != 0) begin
      it = file_bytes.pop_back();
      it.final_byte = 1'b1;
      file_bytes.push_back(it);
    end
  endtask

  // Result side: random back-pressure bursts plus one long hold-off on request
  initial begin : result_sink
    int hold_left;
    int gap_left;
    bit stall_done;
    hold_left  = 0;
    gap_left   = 0;
    stall_done = 1'b0;
    pix_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req && !stall_done) begin
        hold_left  = LONG_HOLD;
        stall_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_ch.ready <= 1'b0;
      end else if (quiet) begin
        pix_ch.ready <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        pix_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 12);
        pix_ch.ready <= 1'b0;
      end else begin
        pix_ch.ready <= 1'b1;
      end
    end
  end

  function automatic bit result_mismatch(tga_pkg::out_item_t got, tga_pkg::out_item_t want);
    return (got.pixel_value     !== want.pixel_value)   ||
           (got.repeat_count    !== want.repeat_count)  ||
           (got.pixel_present   !== want.pixel_present) ||
           (got.image_done      !== want.image_done)    ||
           (got.decode_status   !== want.decode_status) ||
           (got.image_width     !== want.image_width)   ||
           (got.image_height    !== want.image_height)  ||
           (got.pixel_bytes     !== want.pixel_bytes)   ||
           (got.header_accepted !== want.header_accepted);
  endfunction

  task automatic show_result(string tag, tga_pkg::out_item_t r);
    $display("  %s pix=%h rep=%0d present=%b done=%b status=%0d w=%0d h=%0d bytes=%0d hdr=%b",
             tag, r.pixel_value, r.repeat_count, r.pixel_present, r.image_done,
             r.decode_status, r.image_width, r.image_height, r.pixel_bytes,
             r.header_accepted);
  endtask

  always @(posedge clk) begin
    tga_pkg::out_item_t want;
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      if (pix_ch.payload.pixel_present) pixel_results++;
      else status_results++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: result with nothing pending", $realtime);
          show_result("got ", pix_ch.payload);
        end
      end else begin
        want = pending_results.pop_front();
        if (result_mismatch(pix_ch.payload, want)) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: result mismatch", $realtime);
            show_result("want", want);
            show_result("got ", pix_ch.payload);
          end
        end
      end
    end
  end

  initial begin : stimulus
    bit odd;
    int i;
    byte_ch.valid   <= 1'b0;
    byte_ch.payload <= '0;
    quiet           = 1'b0;
    stall_req       <= 1'b0;
    errors          = 0;
    busy_items      = 0;
    pixel_results   = 0;
    status_results  = 0;
    files_sent      = 0;
    odd_files       = 0;
    clear_decoder();

    // truncation straight out of reset
    add_row(8'h00, 1'b0, 1'b1, 1'b1,
            mk_out(32'h0, 8'd0, 1'b0, 1'b0, tga_pkg::STATUS_TRUNCATED, 16'd0, 16'd0,
                   3'd0, 1'b0));
    // RLE header: 2x1, 32 bpp
    add_row(8'h00, 1'b1, 1'b0);
    add_row(8'h00, 1'b0, 1'b0);
    add_row(tga_pkg::TYPE_RLE, 1'b0, 1'b0);
    for (i = 3; i < 12; i++) add_row(8'h00, 1'b0, 1'b0);
    add_row(8'h02, 1'b0, 1'b0);
    add_row(8'h00, 1'b0, 1'b0);
    add_row(8'h01, 1'b0, 1'b0);
    add_row(8'h00, 1'b0, 1'b0);
    add_row(tga_pkg::BPP_32, 1'b0, 1'b0);
    add_row(8'hFF, 1'b0, 1'b0, 1'b1,
            mk_out(32'h0, 8'd0, 1'b0, 1'b0, tga_pkg::STATUS_OK, 16'd2, 16'd1, 3'd4, 1'b1));
    // longest run, clipped to the two pixels of the image
    add_row(8'hFF, 1'b0, 1'b0);
    add_row(8'hFF, 1'b0, 1'b0);
    add_row(8'hFF, 1'b0, 1'b0);
    add_row(8'hFF, 1'b0, 1'b0);
    add_row(8'hFF, 1'b0, 1'b0, 1'b1,
            mk_out(32'hFFFF_FFFF, 8'd2, 1'b1, 1'b1, tga_pkg::STATUS_OK, 16'd2, 16'd1,
                   3'd4, 1'b0));
    // trailing byte after the image, ignored even with final set
    add_row(8'h55, 1'b0, 1'b1);

    while (rst !== 1'b0) @(posedge clk);

    foreach (dir_table[k]) feed_byte(dir_table[k].item, dir_table[k].typed, dir_table[k].want);

    while (busy_items < TARGET_ITEMS) begin
      build_file(odd);
      files_sent++;
      if (odd) odd_files++;
      if (files_sent == 3) stall_req <= 1'b1;
      if (busy_items >= QUIET_AFTER) quiet = 1'b1;
      foreach (file_bytes[k]) feed_byte(file_bytes[k], 1'b0, '0);
      if (files_sent == 6) begin
        // let the decoder drain completely before the next file
        byte_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
      end
    end

    byte_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Decoded %0d random files (%0d corrupt, cut short or noise) after the table.",
             files_sent, odd_files);
    $display("Checked %0d pixel transactions and %0d header/status transactions, %0d errors.",
             pixel_results, status_results, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
